/* hdl/uart_rx_tx_ring_buffers_defines.svh */
// ----------------------------------------------------------------------------
// uart_rx_tx_ring_buffers_defines
// Assertion macros for the serial port ring buffers.
// ----------------------------------------------------------------------------
`ifndef UART_RX_TX_RING_BUFFERS_DEFINES_SVH
`define UART_RX_TX_RING_BUFFERS_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset.
`define URTRB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("urtrb assertion failed");
// Next-cycle implication, checked outside reset.
`define URTRB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("urtrb assertion failed");
`else
`define URTRB_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define URTRB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* hdl/urtrb_pkg.sv */
// ----------------------------------------------------------------------------
// urtrb_pkg
// Depths, pointer widths, operation codes and shared types of the ring buffers.
// ----------------------------------------------------------------------------
`default_nettype none

package urtrb_pkg;

	localparam int RX_DEPTH = 256;
	localparam int TX_DEPTH = 256;
	localparam int RX_PTR_W = $clog2(RX_DEPTH);
	localparam int TX_PTR_W = $clog2(TX_DEPTH);
	localparam int RX_CNT_W = RX_PTR_W + 1;
	localparam int TX_CNT_W = TX_PTR_W + 1;

	typedef enum logic [2:0] {
		OP_RX_BYTE  = 3'd0,
		OP_TX_READY = 3'd1,
		OP_READ     = 3'd2,
		OP_WRITE    = 3'd3,
		OP_DRAIN    = 3'd4
	} op_t;

	typedef struct packed {
		logic                we;
		logic [RX_PTR_W-1:0] waddr;
		logic [7:0]          wdata;
		logic                re;
		logic [RX_PTR_W-1:0] raddr;
	} rx_cmd_t;

	typedef struct packed {
		logic                we;
		logic [TX_PTR_W-1:0] waddr;
		logic [7:0]          wdata;
		logic                re;
		logic [TX_PTR_W-1:0] raddr;
	} tx_cmd_t;

	typedef struct packed {
		logic       strobe;
		logic       read_valid;
		logic       line_valid;
		logic       line_from_ring;
		logic [7:0] line_data;
		logic       notify;
		logic       failed;
		logic [7:0] rx_count;
		logic [7:0] tx_space;
		logic       irq;
	} res_t;

	function automatic logic [RX_PTR_W-1:0] rx_bump(input logic [RX_PTR_W-1:0] p);
		return (p == RX_PTR_W'(RX_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [TX_PTR_W-1:0] tx_bump(input logic [TX_PTR_W-1:0] p);
		return (p == TX_PTR_W'(TX_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [RX_CNT_W-1:0] rx_used(input logic [RX_PTR_W-1:0] head,
			input logic [RX_PTR_W-1:0] tail);
		return (tail >= head) ? ({1'b0, tail} - {1'b0, head})
			: ({1'b0, tail} + RX_CNT_W'(RX_DEPTH) - {1'b0, head});
	endfunction

	function automatic logic [TX_CNT_W-1:0] tx_used(input logic [TX_PTR_W-1:0] head,
			input logic [TX_PTR_W-1:0] tail);
		return (tail >= head) ? ({1'b0, tail} - {1'b0, head})
			: ({1'b0, tail} + TX_CNT_W'(TX_DEPTH) - {1'b0, head});
	endfunction

	// Clamp a count to the 8-bit status field.
	function automatic logic [7:0] sat8(input logic [31:0] v);
		return (v > 32'd255) ? 8'hFF : v[7:0];
	endfunction

endpackage

`default_nettype wire

/* hdl/urtrb_ram.sv */
// ----------------------------------------------------------------------------
// urtrb_ram
// Simple dual-port byte RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module urtrb_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* hdl/urtrb_ctrl.sv */
// ----------------------------------------------------------------------------
// urtrb_ctrl
// Ring pointers, transmit interrupt flag and sync mode; issues RAM accesses
// and registers the status of each word.
// ----------------------------------------------------------------------------
`default_nettype none

module urtrb_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [2:0]       operation,
	input  wire logic [7:0]       data_byte,
	input  wire logic             cfg_we,
	input  wire logic             cfg_sync,
	output      urtrb_pkg::rx_cmd_t rx_cmd,
	output      urtrb_pkg::tx_cmd_t tx_cmd,
	output      urtrb_pkg::res_t    res
);
	import urtrb_pkg::*;

	logic [RX_PTR_W-1:0] rx_head_q, rx_tail_q, rx_head_d, rx_tail_d;
	logic [TX_PTR_W-1:0] tx_head_q, tx_tail_q, tx_head_d, tx_tail_d;
	logic                irq_q, irq_d;
	logic                sync_q;
	logic                tx_full;
	res_t                res_d;
	res_t                res_s1;

	assign tx_full = (tx_used(tx_head_q, tx_tail_q) == TX_CNT_W'(TX_DEPTH - 1));

	always_comb begin
		rx_head_d = rx_head_q;
		rx_tail_d = rx_tail_q;
		tx_head_d = tx_head_q;
		tx_tail_d = tx_tail_q;
		irq_d     = irq_q;
		rx_cmd    = '0;
		tx_cmd    = '0;
		res_d     = '0;
		rx_cmd.waddr = rx_tail_q;
		rx_cmd.wdata = data_byte;
		rx_cmd.raddr = rx_head_q;
		tx_cmd.waddr = tx_tail_q;
		tx_cmd.wdata = data_byte;
		tx_cmd.raddr = tx_head_q;
		if (start) begin
			unique case (op_t'(operation))
				OP_RX_BYTE: begin
					rx_cmd.we    = 1'b1;
					rx_tail_d    = rx_bump(rx_tail_q);
					res_d.notify = 1'b1;
				end
				OP_TX_READY: begin
					if (!sync_q && irq_q) begin
						if (tx_head_q != tx_tail_q) begin
							tx_cmd.re            = 1'b1;
							res_d.line_valid     = 1'b1;
							res_d.line_from_ring = 1'b1;
							tx_head_d            = tx_bump(tx_head_q);
						end
						if (tx_head_d == tx_tail_q) begin
							irq_d = 1'b0;
						end
					end
				end
				OP_READ: begin
					if (rx_head_q != rx_tail_q) begin
						rx_cmd.re        = 1'b1;
						res_d.read_valid = 1'b1;
						rx_head_d        = rx_bump(rx_head_q);
					end
				end
				OP_WRITE: begin
					if (sync_q) begin
						res_d.line_valid = 1'b1;
						res_d.line_data  = data_byte;
					end else begin
						if (tx_full) begin
							res_d.failed = 1'b1;
						end else begin
							tx_cmd.we = 1'b1;
							tx_tail_d = tx_bump(tx_tail_q);
						end
						irq_d = 1'b1;
					end
				end
				OP_DRAIN: begin
					tx_head_d = '0;
					tx_tail_d = '0;
				end
				default: begin
				end
			endcase
			res_d.strobe   = 1'b1;
			res_d.rx_count = sat8(32'(rx_used(rx_head_d, rx_tail_d)));
			res_d.tx_space = sat8(32'(TX_CNT_W'(TX_DEPTH - 1) - tx_used(tx_head_d, tx_tail_d)));
			res_d.irq      = irq_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_head_q <= '0;
			rx_tail_q <= '0;
			tx_head_q <= '0;
			tx_tail_q <= '0;
			irq_q     <= 1'b0;
			sync_q    <= 1'b0;
			res_s1    <= '0;
		end else begin
			rx_head_q <= rx_head_d;
			rx_tail_q <= rx_tail_d;
			tx_head_q <= tx_head_d;
			tx_tail_q <= tx_tail_d;
			irq_q     <= irq_d;
			res_s1    <= res_d;
			if (cfg_we) begin
				sync_q <= cfg_sync;
			end
		end
	end

	assign res = res_s1;

endmodule

`default_nettype wire

/* hdl/uart_rx_tx_ring_buffers.sv */
// ----------------------------------------------------------------------------
// uart_rx_tx_ring_buffers
// Receive and transmit byte rings for a serial port, held in two block RAMs.
// ----------------------------------------------------------------------------
//
//  channel   signals                              handshake
//  -------   -----------------------------------  ------------------------
//  command   operation, data_byte                 start && !busy
//  result    read_byte .. tx_irq_active           done, one cycle, no stall
//  config    cfg_data (sync_mode)                 cfg_valid && cfg_ready
//
//  A word is accepted at an edge and its result shows with done in the
//  following cycle; a new word may be accepted every cycle, since busy
//  never rises. The registered read of the RAM sets when the result shows.
//  Reset clears both rings' pointers, the transmit interrupt and sync mode;
//  RAM contents are not cleared. The result cannot be stalled.
//
`default_nettype none
`include "uart_rx_tx_ring_buffers_defines.svh"

module uart_rx_tx_ring_buffers (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output      logic       busy,
	input  wire logic [2:0] operation,
	input  wire logic [7:0] data_byte,
	output      logic       done,
	output      logic [7:0] read_byte,
	output      logic       read_valid,
	output      logic [7:0] line_byte,
	output      logic       line_valid,
	output      logic       rx_notify,
	output      logic       write_failed,
	output      logic [7:0] rx_count,
	output      logic [7:0] tx_space,
	output      logic       tx_irq_active,
	input  wire logic       cfg_valid,
	output      logic       cfg_ready,
	input  wire logic       cfg_data
);
	import urtrb_pkg::*;

	rx_cmd_t    rx_cmd;
	tx_cmd_t    tx_cmd;
	res_t       res;
	logic [7:0] rx_rdata;
	logic [7:0] tx_rdata;

	// Every access to a ring touches one entry only, and a word never reads
	// and writes the same ring, so no forwarding is needed.
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	urtrb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.data_byte (data_byte),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_sync  (cfg_data),
		.rx_cmd    (rx_cmd),
		.tx_cmd    (tx_cmd),
		.res       (res)
	);

	urtrb_ram #(.DEPTH(RX_DEPTH), .WIDTH(8)) u_rx_ram (
		.clk   (clk),
		.we    (rx_cmd.we),
		.waddr (rx_cmd.waddr),
		.wdata (rx_cmd.wdata),
		.re    (rx_cmd.re),
		.raddr (rx_cmd.raddr),
		.rdata (rx_rdata)
	);

	urtrb_ram #(.DEPTH(TX_DEPTH), .WIDTH(8)) u_tx_ram (
		.clk   (clk),
		.we    (tx_cmd.we),
		.waddr (tx_cmd.waddr),
		.wdata (tx_cmd.wdata),
		.re    (tx_cmd.re),
		.raddr (tx_cmd.raddr),
		.rdata (tx_rdata)
	);

	// Zero the byte fields when they carry nothing; pick the line byte from
	// the ring or from the sync-mode bypass.
	assign done          = res.strobe;
	assign read_valid    = res.read_valid;
	assign read_byte     = res.read_valid ? rx_rdata : 8'h00;
	assign line_valid    = res.line_valid;
	assign line_byte     = !res.line_valid ? 8'h00
		: (res.line_from_ring ? tx_rdata : res.line_data);
	assign rx_notify     = res.notify;
	assign write_failed  = res.failed;
	assign rx_count      = res.rx_count;
	assign tx_space      = res.tx_space;
	assign tx_irq_active = res.irq;

	`URTRB_ASSERT_NEXT(a_done_follows_start, clk, arst_n, start && !busy, done)
	`URTRB_ASSERT_NOW(a_fail_means_full, clk, arst_n, done && write_failed,
		tx_space == 8'h00 && tx_irq_active)
	`URTRB_ASSERT_NOW(a_one_effect, clk, arst_n, done && read_valid,
		!rx_notify && !line_valid && !write_failed)
	`URTRB_ASSERT_NOW(a_quiet_without_done, clk, arst_n, !done,
		!read_valid && !line_valid && !rx_notify && !write_failed)

endmodule

`default_nettype wire

/* sim/tb_uart_rx_tx_ring_buffers.sv */
// ----------------------------------------------------------------------------
// tb_uart_rx_tx_ring_buffers
// Self-checking bench for the serial port receive and transmit rings. Command
// words go in through start/busy in random bursts. A cycle model of both rings
// predicts each status word. The result is checked against the
// oldest prediction. The sync mode register is toggled between phases.
// ----------------------------------------------------------------------------

module tb_uart_rx_tx_ring_buffers;

	import urtrb_pkg::*;

	// Codes past drain have no function; the block must only report status.
	localparam logic [2:0] OP_SPARE_LO = 3'd5;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;
	localparam int IDLE_LIMIT = 1000;

	typedef struct {
		logic [2:0] op;
		logic [7:0] data;
	} port_word_t;

	typedef struct {
		logic [7:0] rd_byte;
		logic       rd_ok;
		logic [7:0] ln_byte;
		logic       ln_ok;
		logic       stored;
		logic       full;
		logic [7:0] rx_level;
		logic [7:0] tx_free;
		logic       irq;
	} ring_status_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic [2:0] operation = OP_RX_BYTE;
	logic [7:0] data_byte = 8'h00;
	logic       cfg_valid = 1'b0;
	logic       cfg_data = 1'b0;
	logic       busy;
	logic       done;
	logic [7:0] read_byte;
	logic       read_valid;
	logic [7:0] line_byte;
	logic       line_valid;
	logic       rx_notify;
	logic       write_failed;
	logic [7:0] rx_count;
	logic [7:0] tx_space;
	logic       tx_irq_active;
	logic       cfg_ready;

	uart_rx_tx_ring_buffers u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.data_byte    (data_byte),
		.done         (done),
		.read_byte    (read_byte),
		.read_valid   (read_valid),
		.line_byte    (line_byte),
		.line_valid   (line_valid),
		.rx_notify    (rx_notify),
		.write_failed (write_failed),
		.rx_count     (rx_count),
		.tx_space     (tx_space),
		.tx_irq_active(tx_irq_active),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Ring model: own copy of both stores, pointers, interrupt and mode.
	// ------------------------------------------------------------------
	logic [7:0]          rx_mem [RX_DEPTH];
	logic [7:0]          tx_mem [TX_DEPTH];
	logic [RX_PTR_W-1:0] rx_rd_ptr = '0;
	logic [RX_PTR_W-1:0] rx_wr_ptr = '0;
	logic [TX_PTR_W-1:0] tx_rd_ptr = '0;
	logic [TX_PTR_W-1:0] tx_wr_ptr = '0;
	logic                tx_irq_on = 1'b0;
	logic                sync_on = 1'b0;

	port_word_t   pending_words[$];
	ring_status_t expected_status[$];
	int           error_count = 0;
	logic         taken = 1'b0;

	function automatic int ring_fill(int head, int tail, int depth);
		return (tail >= head) ? tail - head : tail + depth - head;
	endfunction

	function automatic logic [7:0] clamp_status(int v);
		return (v > 255) ? 8'hFF : v[7:0];
	endfunction

	// Apply one command word to the model and return the status it reports.
	function automatic ring_status_t predict_ring(logic [2:0] op, logic [7:0] d);
		ring_status_t r;
		r = '{default: '0};
		case (op)
			OP_RX_BYTE: begin
				// No full check: a wrap onto the read pointer empties the ring.
				rx_mem[rx_wr_ptr] = d;
				rx_wr_ptr = (int'(rx_wr_ptr) + 1 >= RX_DEPTH) ? '0 : rx_wr_ptr + 1'b1;
				r.stored = 1'b1;
			end
			OP_TX_READY: begin
				if (!sync_on && tx_irq_on) begin
					if (tx_rd_ptr != tx_wr_ptr) begin
						r.ln_byte = tx_mem[tx_rd_ptr];
						r.ln_ok = 1'b1;
						tx_rd_ptr = (int'(tx_rd_ptr) + 1 >= TX_DEPTH) ? '0 : tx_rd_ptr + 1'b1;
					end
					if (tx_rd_ptr == tx_wr_ptr)
						tx_irq_on = 1'b0;
				end
			end
			OP_READ: begin
				if (rx_rd_ptr != rx_wr_ptr) begin
					r.rd_byte = rx_mem[rx_rd_ptr];
					r.rd_ok = 1'b1;
					rx_rd_ptr = (int'(rx_rd_ptr) + 1 >= RX_DEPTH) ? '0 : rx_rd_ptr + 1'b1;
				end
			end
			OP_WRITE: begin
				if (sync_on) begin
					r.ln_byte = d;
					r.ln_ok = 1'b1;
				end else begin
					if (TX_DEPTH - 1 - ring_fill(tx_rd_ptr, tx_wr_ptr, TX_DEPTH) > 0) begin
						tx_mem[tx_wr_ptr] = d;
						tx_wr_ptr = (int'(tx_wr_ptr) + 1 >= TX_DEPTH) ? '0 : tx_wr_ptr + 1'b1;
					end else begin
						r.full = 1'b1;
					end
					// The interrupt comes on even when the word is dropped.
					tx_irq_on = 1'b1;
				end
			end
			OP_DRAIN: begin
				tx_rd_ptr = '0;
				tx_wr_ptr = '0;
			end
			default: ;
		endcase
		r.rx_level = clamp_status(ring_fill(rx_rd_ptr, rx_wr_ptr, RX_DEPTH));
		r.tx_free = clamp_status(TX_DEPTH - 1 - ring_fill(tx_rd_ptr, tx_wr_ptr, TX_DEPTH));
		r.irq = tx_irq_on;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
		$display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
		error_count++;
	endtask

	task automatic check_field(string what, logic [7:0] got, logic [7:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	// ------------------------------------------------------------------
	// Monitor: check the result word first, then predict the word taken
	// at this edge, so a result never meets its own prediction.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		ring_status_t want;
		if (!arst_n) begin
			taken <= 1'b0;
		end else begin
			if (done) begin
				if (expected_status.size() == 0) begin
					report_mismatch("unexpected result word", rx_count, 8'h00);
				end else begin
					want = expected_status.pop_front();
					check_field("read_byte", read_byte, want.rd_byte);
					check_field("read_valid", 8'(read_valid), 8'(want.rd_ok));
					check_field("line_byte", line_byte, want.ln_byte);
					check_field("line_valid", 8'(line_valid), 8'(want.ln_ok));
					check_field("rx_notify", 8'(rx_notify), 8'(want.stored));
					check_field("write_failed", 8'(write_failed), 8'(want.full));
					check_field("rx_count", rx_count, want.rx_level);
					check_field("tx_space", tx_space, want.tx_free);
					check_field("tx_irq_active", 8'(tx_irq_active), 8'(want.irq));
				end
			end
			if (start && !busy)
				expected_status.push_back(predict_ring(operation, data_byte));
			if (cfg_valid && cfg_ready)
				sync_on = cfg_data;
			taken <= start && !busy;
		end
	end

	// ------------------------------------------------------------------
	// Driver: present the oldest pending word in bursts; drop it from the
	// queue once taken. Now and then hold off until every result is in.
	// ------------------------------------------------------------------
	int burst_left = 0;
	int gap_left = 0;
	bit settle = 1'b0;
	bit settled_once = 1'b0;

	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (taken)
				void'(pending_words.pop_front());
			if (burst_left == 0) begin
				if ($urandom_range(0, 7) == 0) begin
					// Long stretch with no idle gap.
					burst_left = $urandom_range(100, 300);
					gap_left = 0;
				end else begin
					burst_left = $urandom_range(1, 24);
					gap_left = $urandom_range(0, 8);
				end
				settle = !settled_once || ($urandom_range(0, 15) == 0);
			end
			if (settle && expected_status.size() != 0) begin
				start <= 1'b0;
			end else begin
				if (settle && pending_words.size() != 0)
					settled_once = 1'b1;
				settle = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (pending_words.size() == 0) begin
					start <= 1'b0;
				end else begin
					start <= 1'b1;
					operation <= pending_words[0].op;
					data_byte <= pending_words[0].data;
					burst_left--;
				end
			end
		end
	end

	// Watchdog: end the run if nothing moves for too long.
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	task automatic push_word(logic [2:0] op, logic [7:0] d);
		port_word_t w;
		w.op = op;
		w.data = d;
		pending_words.push_back(w);
	endtask

	task automatic wait_idle();
		while (pending_words.size() != 0 || expected_status.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_sync_mode(logic v);
		@(negedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Queue n writes to the transmit ring, filling it and past it for large n, then send some out.
	task automatic fill_tx_ring(int n);
		repeat (n)
			push_word(OP_WRITE, 8'($urandom));
		repeat ($urandom_range(n / 4, n))
			push_word(OP_TX_READY, 8'($urandom));
	endtask

	// Queue n received bytes, wrapping the ring onto its read pointer for large n, then read some back.
	task automatic overflow_rx_ring(int n);
		repeat (n)
			push_word(OP_RX_BYTE, 8'($urandom));
		repeat ($urandom_range(1, 40))
			push_word(OP_READ, 8'($urandom));
	endtask

	// Mostly well-formed traffic with random content; a little noise.
	task automatic random_traffic(int n);
		int added;
		int pick;
		added = 0;
		while (added < n) begin
			pick = $urandom_range(0, 24);
			if (pick == 0) begin
				fill_tx_ring($urandom_range(200, 260));
				added += 200;
			end else if (pick == 1) begin
				overflow_rx_ring($urandom_range(240, 262));
				added += 240;
			end else begin
				repeat ($urandom_range(10, 40)) begin
					pick = $urandom_range(0, 99);
					if (pick < 25)
						push_word(OP_RX_BYTE, 8'($urandom));
					else if (pick < 45)
						push_word(OP_TX_READY, 8'($urandom));
					else if (pick < 70)
						push_word(OP_READ, 8'($urandom));
					else if (pick < 90)
						push_word(OP_WRITE, 8'($urandom));
					else if (pick < 94)
						push_word(OP_DRAIN, 8'($urandom));
					else
						push_word(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), 8'($urandom));
					added++;
				end
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Ring mode, directed: empty cases, extremes, spare codes.
		set_sync_mode(1'b0);
		push_word(OP_READ, 8'h00);
		push_word(OP_TX_READY, 8'hFF);
		push_word(OP_DRAIN, 8'h00);
		for (int c = OP_SPARE_LO; c <= OP_SPARE_HI; c++)
			push_word(3'(c), 8'hFF);
		push_word(OP_WRITE, 8'h00);
		push_word(OP_WRITE, 8'hFF);
		push_word(OP_TX_READY, 8'h00);
		push_word(OP_TX_READY, 8'h00);
		push_word(OP_TX_READY, 8'h00);
		push_word(OP_RX_BYTE, 8'h00);
		push_word(OP_RX_BYTE, 8'hFF);
		push_word(OP_RX_BYTE, 8'hA5);
		push_word(OP_READ, 8'h00);
		push_word(OP_READ, 8'h00);
		push_word(OP_READ, 8'h00);
		push_word(OP_READ, 8'h00);
		push_word(OP_WRITE, 8'h5A);
		// Drain leaves the interrupt on; the next ready event turns it off.
		push_word(OP_DRAIN, 8'h00);
		push_word(OP_TX_READY, 8'h00);
		wait_idle();

		// Sync mode: writes go straight out, ready events do nothing.
		set_sync_mode(1'b1);
		push_word(OP_WRITE, 8'h00);
		push_word(OP_WRITE, 8'hFF);
		push_word(OP_TX_READY, 8'h00);
		push_word(OP_RX_BYTE, 8'h3C);
		push_word(OP_READ, 8'h00);
		random_traffic(150);
		wait_idle();

		// Ring mode with a full transmit ring and a receive wrap up front.
		set_sync_mode(1'b0);
		fill_tx_ring(258);
		overflow_rx_ring(257);
		random_traffic(220);
		wait_idle();

		set_sync_mode(1'b1);
		random_traffic(80);
		wait_idle();

		set_sync_mode(1'b0);
		random_traffic(200);
		wait_idle();

		// Let any stray late result show up before judging.
		repeat (4) @(posedge clk);
		if (error_count == 0 && expected_status.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
